// ----- design/pyr_pkg.sv -----
// Shared types and constants for the packed 4:2:2 / mono10 pixel-word converter.
package pyr_pkg;

  // Layout codes held in the layout register.
  typedef enum logic [1:0] {
    LAYOUT_YUYV = 2'd0,
    LAYOUT_UYVY = 2'd1,
    LAYOUT_MONO = 2'd2,
    LAYOUT_NONE = 2'd3
  } layout_e;

  // Q15 matrix coefficients.
  localparam int CoefW = 18;
  localparam logic signed [CoefW-1:0] CoefRv = 18'sd37221;
  localparam logic signed [CoefW-1:0] CoefGu = 18'sd12975;
  localparam logic signed [CoefW-1:0] CoefGv = 18'sd18949;
  localparam logic signed [CoefW-1:0] CoefBu = 18'sd66883;
  localparam int FracBits = 15;

  // Product width and width of the shifted chroma offsets.
  localparam int ProdW = 26;
  localparam int OffW  = 10;

  // Chroma offsets shared by both pixel lanes.
  typedef struct packed {
    logic signed [OffW-1:0] r_off;
    logic signed [OffW-1:0] g_off;
    logic signed [OffW-1:0] b_off;
  } chroma_off_t;

  // One clamped RGB888 pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Reduce a little-endian 10-bit sample to its top eight bits.
  function automatic logic [7:0] mono8(input logic [7:0] lo, input logic [7:0] hi);
    mono8 = {hi[1:0], lo[7:2]};
  endfunction

endpackage

// ----- design/pyr_chroma.sv -----
// Chroma stage: shared U/V products turned into floor-shifted channel offsets.
module pyr_chroma import pyr_pkg::*; (
  input  logic [7:0]  u_i,
  input  logic [7:0]  v_i,
  output chroma_off_t off_o
);

  logic signed [7:0]       u_s;
  logic signed [7:0]       v_s;
  logic signed [ProdW-1:0] r_prod;
  logic signed [ProdW-1:0] g_sum;
  logic signed [ProdW-1:0] b_prod;

  // Removing the 128 bias is the same as flipping the top bit.
  assign u_s = signed'({~u_i[7], u_i[6:0]});
  assign v_s = signed'({~v_i[7], v_i[6:0]});

  // Constant-coefficient products; the arithmetic shift gives the floor.
  assign r_prod = ProdW'(v_s) * ProdW'(CoefRv);
  assign g_sum  = ProdW'(u_s) * ProdW'(CoefGu) + ProdW'(v_s) * ProdW'(CoefGv);
  assign b_prod = ProdW'(u_s) * ProdW'(CoefBu);

  assign off_o.r_off = OffW'(r_prod >>> FracBits);
  assign off_o.g_off = OffW'(g_sum >>> FracBits);
  assign off_o.b_off = OffW'(b_prod >>> FracBits);

endmodule

// ----- design/pyr_lane.sv -----
// Pixel lane: adds the red and blue chroma offsets to one luma sample, subtracts the green one, and clamps.
module pyr_lane import pyr_pkg::*; (
  input  logic [7:0]  y_i,
  input  chroma_off_t off_i,
  output rgb_t        pix_o
);

  localparam int SumW = OffW + 1;

  logic signed [SumW-1:0] y_s;
  logic signed [SumW-1:0] r_sum;
  logic signed [SumW-1:0] g_sum;
  logic signed [SumW-1:0] b_sum;

  // Saturate a channel sum to the range 0..255.
  function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] v);
    if (v < 0) begin
      clamp8 = 8'd0;
    end else if (v > SumW'(255)) begin
      clamp8 = 8'hFF;
    end else begin
      clamp8 = v[7:0];
    end
  endfunction

  assign y_s   = signed'({{(SumW-8){1'b0}}, y_i});
  assign r_sum = y_s + SumW'(off_i.r_off);
  assign g_sum = y_s - SumW'(off_i.g_off);
  assign b_sum = y_s + SumW'(off_i.b_off);

  assign pix_o.red   = clamp8(r_sum);
  assign pix_o.green = clamp8(g_sum);
  assign pix_o.blue  = clamp8(b_sum);

endmodule

// ----- design/pyr_merge.sv -----
// Merge stage: selects lane or mono results by layout into the output register.
module pyr_merge import pyr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  layout_e    layout_i,
  input  rgb_t       pix_first_i,
  input  rgb_t       pix_second_i,
  input  logic [7:0] mono_first_i,
  input  logic [7:0] mono_second_i,
  input  logic       frame_end_i,
  output logic       valid_o,
  output rgb_t       pix_first_o,
  output rgb_t       pix_second_o,
  output logic [7:0] mono_first_o,
  output logic [7:0] mono_second_o,
  output logic       frame_end_o
);

  logic       valid_q;
  rgb_t       pix_first_d, pix_first_q;
  rgb_t       pix_second_d, pix_second_q;
  logic [7:0] mono_first_d, mono_first_q;
  logic [7:0] mono_second_d, mono_second_q;
  logic       frame_end_q;

  // Zero the fields that the layout does not use.
  always_comb begin
    pix_first_d   = '0;
    pix_second_d  = '0;
    mono_first_d  = '0;
    mono_second_d = '0;
    unique case (layout_i)
      LAYOUT_YUYV, LAYOUT_UYVY: begin
        pix_first_d  = pix_first_i;
        pix_second_d = pix_second_i;
      end
      LAYOUT_MONO: begin
        mono_first_d  = mono_first_i;
        mono_second_d = mono_second_i;
      end
      default: begin
      end
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    pix_first_q   <= pix_first_d;
    pix_second_q  <= pix_second_d;
    mono_first_q  <= mono_first_d;
    mono_second_q <= mono_second_d;
    frame_end_q   <= frame_end_i;
  end

  assign valid_o       = valid_q;
  assign pix_first_o   = pix_first_q;
  assign pix_second_o  = pix_second_q;
  assign mono_first_o  = mono_first_q;
  assign mono_second_o = mono_second_q;
  assign frame_end_o   = frame_end_q;

endmodule

// ----- design/packed_yuv422_to_rgb.sv -----
// Top level of the packed 4:2:2 / mono10 to RGB888 pixel-word converter.
//
//   Channel   Signals                                  Handshake
//   --------  ---------------------------------------  --------------------------
//   input     byte_0_i..byte_3_i, frame_end_i          start_i high, busy_o low
//   result    red/green/blue_first/second_o, mono_*_o,  result_valid_o, one cycle
//             frame_end_out_o
//   config    cfg_data_i                               cfg_we_i
//
// A word is taken on every cycle that start_i is high; busy_o is never raised.
// Each result passes through one register after the chroma multipliers and one in
// the merge stage behind the two pixel lanes.
// Reset clears the layout register to YUYV and the valid pipeline; nothing is pending.
// The receiver cannot stall, so no transaction is ever held back.
module packed_yuv422_to_rgb import pyr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] byte_0_i,
  input  logic [7:0] byte_1_i,
  input  logic [7:0] byte_2_i,
  input  logic [7:0] byte_3_i,
  input  logic       frame_end_i,
  output logic       result_valid_o,
  output logic [7:0] red_first_o,
  output logic [7:0] green_first_o,
  output logic [7:0] blue_first_o,
  output logic [7:0] red_second_o,
  output logic [7:0] green_second_o,
  output logic [7:0] blue_second_o,
  output logic [7:0] mono_first_o,
  output logic [7:0] mono_second_o,
  output logic       frame_end_out_o
);

  layout_e     layout_q;
  logic        accept;
  logic [7:0]  y0_d, y1_d, u_sel, v_sel;
  chroma_off_t off_d;

  logic        s1_valid_q;
  layout_e     s1_layout_q;
  logic [7:0]  s1_y0_q, s1_y1_q;
  chroma_off_t s1_off_q;
  logic [7:0]  s1_mono0_q, s1_mono1_q;
  logic        s1_frame_end_q;

  rgb_t        lane_first, lane_second;
  rgb_t        out_first, out_second;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Layout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= LAYOUT_YUYV;
    end else if (cfg_we_i) begin
      layout_q <= layout_e'(cfg_data_i);
    end
  end

  // Pick luma and chroma bytes according to the byte order.
  always_comb begin
    if (layout_q == LAYOUT_UYVY) begin
      u_sel = byte_0_i;
      y0_d  = byte_1_i;
      v_sel = byte_2_i;
      y1_d  = byte_3_i;
    end else begin
      y0_d  = byte_0_i;
      u_sel = byte_1_i;
      y1_d  = byte_2_i;
      v_sel = byte_3_i;
    end
  end

  pyr_chroma u_chroma (
    .u_i   (u_sel),
    .v_i   (v_sel),
    .off_o (off_d)
  );

  // First pipeline register, after the multipliers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_layout_q    <= layout_q;
    s1_y0_q        <= y0_d;
    s1_y1_q        <= y1_d;
    s1_off_q       <= off_d;
    s1_mono0_q     <= mono8(byte_0_i, byte_1_i);
    s1_mono1_q     <= mono8(byte_2_i, byte_3_i);
    s1_frame_end_q <= frame_end_i;
  end

  // Two pixel lanes sharing one set of chroma offsets.
  pyr_lane u_lane_first (
    .y_i   (s1_y0_q),
    .off_i (s1_off_q),
    .pix_o (lane_first)
  );

  pyr_lane u_lane_second (
    .y_i   (s1_y1_q),
    .off_i (s1_off_q),
    .pix_o (lane_second)
  );

  pyr_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid_q),
    .layout_i      (s1_layout_q),
    .pix_first_i   (lane_first),
    .pix_second_i  (lane_second),
    .mono_first_i  (s1_mono0_q),
    .mono_second_i (s1_mono1_q),
    .frame_end_i   (s1_frame_end_q),
    .valid_o       (result_valid_o),
    .pix_first_o   (out_first),
    .pix_second_o  (out_second),
    .mono_first_o  (mono_first_o),
    .mono_second_o (mono_second_o),
    .frame_end_o   (frame_end_out_o)
  );

  assign red_first_o    = out_first.red;
  assign green_first_o  = out_first.green;
  assign blue_first_o   = out_first.blue;
  assign red_second_o   = out_second.red;
  assign green_second_o = out_second.green;
  assign blue_second_o  = out_second.blue;

endmodule

// ----- design/pyr_checker.sv -----
// Port-level checks for the pixel-word converter, bound to its top level.
module pyr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       frame_end_i,
  input logic       result_valid_o,
  input logic [7:0] red_first_o,
  input logic [7:0] green_first_o,
  input logic [7:0] blue_first_o,
  input logic [7:0] red_second_o,
  input logic [7:0] green_second_o,
  input logic [7:0] blue_second_o,
  input logic [7:0] mono_first_o,
  input logic       frame_end_out_o
);

  // Every accepted transaction yields a result once it has passed the pipeline registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 result_valid_o)
    else $error("accepted transaction gave no result");

  // No result appears without an accepted transaction behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without accepted transaction");

  // The frame-end mark travels with its transaction.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (frame_end_out_o == $past(frame_end_i, 2)))
    else $error("frame-end mark lost or misplaced");

  // A non-zero first mono value means the colour fields are all zero.
  a_mono_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && mono_first_o != 8'd0) |->
      (red_first_o == 8'd0 && green_first_o == 8'd0 && blue_first_o == 8'd0 &&
       red_second_o == 8'd0 && green_second_o == 8'd0 && blue_second_o == 8'd0))
    else $error("colour fields set in mono layout");

endmodule

bind packed_yuv422_to_rgb pyr_checker u_pyr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .frame_end_i     (frame_end_i),
  .result_valid_o  (result_valid_o),
  .red_first_o     (red_first_o),
  .green_first_o   (green_first_o),
  .blue_first_o    (blue_first_o),
  .red_second_o    (red_second_o),
  .green_second_o  (green_second_o),
  .blue_second_o   (blue_second_o),
  .mono_first_o    (mono_first_o),
  .frame_end_out_o (frame_end_out_o)
);

// ----- sim/packed_yuv422_to_rgb_tb.sv -----
// Self-checking testbench for the packed 4:2:2 / mono10 to RGB888 pixel-word converter.
module packed_yuv422_to_rgb_tb;
  import pyr_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int PIPE_LATENCY  = 2;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 2;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_WORDS   = 162;

  // Q15 matrix coefficients and chroma bias of the conversion.
  localparam int Q15_RV = 37221;
  localparam int Q15_GU = 12975;
  localparam int Q15_GV = 18949;
  localparam int Q15_BU = 66883;
  localparam int CHROMA_BIAS = 128;

  // Kinds of entry in the stimulus plan.
  typedef enum logic [1:0] {
    PLAN_WORD,
    PLAN_LAYOUT,
    PLAN_DRAIN,
    PLAN_GAPS
  } plan_kind_e;

  typedef struct {
    plan_kind_e  kind;
    logic [7:0]  b0, b1, b2, b3;
    logic        fe;
    int unsigned arg;
  } plan_entry_t;

  // One converted word as the block should present it.
  typedef struct packed {
    rgb_t       first;
    rgb_t       second;
    logic [7:0] mono_first;
    logic [7:0] mono_second;
    logic       frame_end;
  } pixel_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_data_i  = 2'd0;
  logic       start_i     = 1'b0;
  logic [7:0] byte_0_i    = 8'd0;
  logic [7:0] byte_1_i    = 8'd0;
  logic [7:0] byte_2_i    = 8'd0;
  logic [7:0] byte_3_i    = 8'd0;
  logic       frame_end_i = 1'b0;
  logic       busy_o;
  logic       result_valid_o;
  logic [7:0] red_first_o, green_first_o, blue_first_o;
  logic [7:0] red_second_o, green_second_o, blue_second_o;
  logic [7:0] mono_first_o, mono_second_o;
  logic       frame_end_out_o;

  plan_entry_t   stream_plan[$];
  pixel_result_t awaited_pixels[$];
  layout_e       active_layout = LAYOUT_YUYV;
  int unsigned   gap_percent   = 0;
  int unsigned   settle_left   = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   words_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   layout_writes = 0;
  int unsigned   fault_count   = 0;
  int unsigned   words_per_layout[4] = '{0, 0, 0, 0};

  packed_yuv422_to_rgb i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .byte_0_i       (byte_0_i),
    .byte_1_i       (byte_1_i),
    .byte_2_i       (byte_2_i),
    .byte_3_i       (byte_3_i),
    .frame_end_i    (frame_end_i),
    .result_valid_o (result_valid_o),
    .red_first_o    (red_first_o),
    .green_first_o  (green_first_o),
    .blue_first_o   (blue_first_o),
    .red_second_o   (red_second_o),
    .green_second_o (green_second_o),
    .blue_second_o  (blue_second_o),
    .mono_first_o   (mono_first_o),
    .mono_second_o  (mono_second_o),
    .frame_end_out_o(frame_end_out_o)
  );

  // Clock generation.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Saturate a channel to the 8-bit range.
  function automatic logic [7:0] clamp_channel(int value);
    if (value < 0) return 8'd0;
    if (value > 255) return 8'd255;
    return value[7:0];
  endfunction

  // Convert one luma sample and its shared chroma pair; >>> on int floors.
  function automatic rgb_t yuv_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    int   y, u, v;
    rgb_t px;
    y = int'(luma);
    u = int'(cb) - CHROMA_BIAS;
    v = int'(cr) - CHROMA_BIAS;
    px.red   = clamp_channel(y + ((v * Q15_RV) >>> 15));
    px.green = clamp_channel(y - ((u * Q15_GU + v * Q15_GV) >>> 15));
    px.blue  = clamp_channel(y + ((u * Q15_BU) >>> 15));
    return px;
  endfunction

  // Work out the result of one packed word under the given layout.
  function automatic pixel_result_t convert_word(layout_e layout, logic [7:0] b0,
                                                 logic [7:0] b1, logic [7:0] b2,
                                                 logic [7:0] b3, logic fe);
    pixel_result_t res;
    res = '0;
    case (layout)
      LAYOUT_YUYV: begin
        res.first  = yuv_pixel(b0, b1, b3);
        res.second = yuv_pixel(b2, b1, b3);
      end
      LAYOUT_UYVY: begin
        res.first  = yuv_pixel(b1, b0, b2);
        res.second = yuv_pixel(b3, b0, b2);
      end
      LAYOUT_MONO: begin
        // Keep the top eight bits of each 10-bit sample.
        res.mono_first  = {b1[1:0], b0[7:2]};
        res.mono_second = {b3[1:0], b2[7:2]};
      end
      default: ;
    endcase
    res.frame_end = fe;
    return res;
  endfunction

  // Compare one result field and report a mismatch.
  function automatic void check_field(string name, logic [7:0] expected_val,
                                      logic [7:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, expected_val, actual_val);
      fault_count++;
    end
  endfunction

  // Byte values leaning towards the extremes and the chroma midpoint.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void plan_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3, logic fe);
    stream_plan.push_back('{PLAN_WORD, b0, b1, b2, b3, fe, 0});
  endfunction

  function automatic void plan_control(plan_kind_e kind, int unsigned arg);
    stream_plan.push_back('{kind, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, arg});
  endfunction

  // Driver: records each accepted transaction and presents the next plan entry.
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic nxt_start;
    logic nxt_we;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      nxt_start = start_i;
      nxt_we    = 1'b0;
      if (start_i && !busy_o) begin
        awaited_pixels.push_back(convert_word(active_layout, byte_0_i, byte_1_i,
                                              byte_2_i, byte_3_i, frame_end_i));
        words_sent++;
        words_per_layout[active_layout]++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (stream_plan.size() > 0) begin
          case (stream_plan[0].kind)
            PLAN_WORD: begin
              if ($urandom_range(99) >= gap_percent) begin
                byte_0_i    <= stream_plan[0].b0;
                byte_1_i    <= stream_plan[0].b1;
                byte_2_i    <= stream_plan[0].b2;
                byte_3_i    <= stream_plan[0].b3;
                frame_end_i <= stream_plan[0].fe;
                nxt_start = 1'b1;
                void'(stream_plan.pop_front());
              end
            end
            PLAN_LAYOUT: begin
              cfg_data_i    <= stream_plan[0].arg[1:0];
              nxt_we        = 1'b1;
              active_layout = layout_e'(stream_plan[0].arg[1:0]);
              layout_writes++;
              void'(stream_plan.pop_front());
            end
            PLAN_DRAIN: begin
              // Hold off until every outstanding result has come back.
              if (awaited_pixels.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(stream_plan.pop_front());
              end
            end
            default: begin
              gap_percent = stream_plan[0].arg;
              void'(stream_plan.pop_front());
            end
          endcase
        end
      end
      start_i  <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin : watch_results
    pixel_result_t exp_px;
    if (rst_ni) begin
      if ($isunknown(result_valid_o)) begin
        $error("result_valid_o is unknown");
        fault_count++;
      end else if (result_valid_o) begin
        results_seen++;
        if (awaited_pixels.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          fault_count++;
        end else begin
          exp_px = awaited_pixels.pop_front();
          check_field("red_first",    exp_px.first.red,    red_first_o);
          check_field("green_first",  exp_px.first.green,  green_first_o);
          check_field("blue_first",   exp_px.first.blue,   blue_first_o);
          check_field("red_second",   exp_px.second.red,   red_second_o);
          check_field("green_second", exp_px.second.green, green_second_o);
          check_field("blue_second",  exp_px.second.blue,  blue_second_o);
          check_field("mono_first",   exp_px.mono_first,   mono_first_o);
          check_field("mono_second",  exp_px.mono_second,  mono_second_o);
          check_field("frame_end_out", 8'(exp_px.frame_end), 8'(frame_end_out_o));
        end
      end
    end
  end

  // Watchdog on the overall run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[packed_yuv422_to_rgb] ERROR");
      $finish;
    end
  end

  // Stimulus plan and end of run.
  initial begin : run_plan
    layout_e     phase_layout[NUM_PHASES];
    int unsigned phase_gaps[4];
    int unsigned pause_at;
    layout_e     lay;
    phase_layout = '{LAYOUT_YUYV, LAYOUT_UYVY, LAYOUT_MONO, LAYOUT_NONE,
                     LAYOUT_UYVY, LAYOUT_YUYV, LAYOUT_MONO, LAYOUT_YUYV,
                     LAYOUT_NONE, LAYOUT_UYVY, LAYOUT_MONO, LAYOUT_YUYV};
    // No gaps, heavy sender gaps, no gaps again (the receiver cannot stall), light gaps.
    phase_gaps = '{0, 49, 0, 25};

    // Directed words in every layout: flat extremes, cross-wired extremes that
    // drive each channel into both clamps, neutral chroma, and mono words with
    // the unused high-byte bits set and clear.
    for (int l = 0; l < 4; l++) begin
      lay = layout_e'(l);
      plan_control(PLAN_DRAIN, 0);
      plan_control(PLAN_LAYOUT, lay);
      plan_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      plan_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      plan_word(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
      plan_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
      plan_word(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
      plan_word(8'hFC, 8'h03, 8'h01, 8'hFE, 1'b1);
    end

    // Random phases, each with a layout from the table and a gap rate shared by three consecutive phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      plan_control(PLAN_DRAIN, 0);
      plan_control(PLAN_LAYOUT, phase_layout[p]);
      plan_control(PLAN_GAPS, phase_gaps[(p / 3) % 4]);
      pause_at = $urandom_range(PHASE_WORDS - 1, 1);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (w == pause_at) plan_control(PLAN_DRAIN, 0);
        plan_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  $urandom_range(7) == 0);
      end
    end
    plan_control(PLAN_GAPS, 0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (stream_plan.size() == 0 && !start_i && awaited_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Converted %0d words into %0d results over %0d layout writes.",
             words_sent, results_seen, layout_writes);
    $display("Words per layout: YUYV %0d, UYVY %0d, mono10 %0d, undefined %0d.",
             words_per_layout[0], words_per_layout[1], words_per_layout[2],
             words_per_layout[3]);
    if (fault_count == 0 && awaited_pixels.size() == 0) begin
      $display("[packed_yuv422_to_rgb] OK");
    end else begin
      $display("[packed_yuv422_to_rgb] ERROR");
    end
    $finish;
  end

endmodule

// ----- packed_yuv422_to_rgb.f -----
design/pyr_pkg.sv
design/pyr_chroma.sv
design/pyr_lane.sv
design/pyr_merge.sv
design/packed_yuv422_to_rgb.sv
design/pyr_checker.sv
sim/packed_yuv422_to_rgb_tb.sv
